// ----- src/nseq_pkg.sv -----
// ----------------------------------------------------------------------------
// nseq_pkg
// shared codes and constants for the note sequencer with release fade
// ----------------------------------------------------------------------------
package nseq_pkg;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // configuration register indexes
  localparam logic REG_LEN_A = 1'b0;
  localparam logic REG_LEN_B = 1'b1;

  // song length after reset
  localparam logic [7:0] LEN_RESET = 8'd4;

  // output volumes: new note and the three fade steps
  localparam logic [4:0] VOL_NOTE   = 5'd31;
  localparam logic [4:0] VOL_FADE_3 = 5'd30;
  localparam logic [4:0] VOL_FADE_2 = 5'd29;
  localparam logic [4:0] VOL_FADE_1 = 5'd28;

  // channel field is one bit wide, so per-channel state has two slots
  localparam int CH_SLOTS = 2;

endpackage

// ----- src/note_sequencer_with_release_fade.sv -----
// ----------------------------------------------------------------------------
// note_sequencer_with_release_fade
// two-channel note sequencer with a three-step release fade
// ----------------------------------------------------------------------------
// Songs are loaded byte by byte (tuser func = load) into a per-channel song
// store of four-byte records: frequency low, frequency high, duration, spare.
// A start transfer plays the first record at volume 31 and arms the channel;
// each tick transfer advances the channel's tick count, fades the volume to
// 30, 29 and 28 on the last three ticks of a note and then plays the next
// record, wrapping the read position modulo the channel's song length.
// One input transfer is taken at a time and s_tready is low while it is
// worked on. A load is written while the sequencer stays idle; ticks with
// no result, fade ticks, starts and ticks that play a new note step through
// the sequencer states. The work is paced by the single 9-bit add/subtract
// unit that the arithmetic steps share, the three back-to-back song store
// reads through its one registered port, and the eight-step restoring
// remainder loop for the position wrap, which a tick that plays a new note
// runs unless the song length is 0. A result sits in an output register, so
// a new input can be taken while m_tvalid is still waiting on m_tready.
// ----------------------------------------------------------------------------
module note_sequencer_with_release_fade #(
  parameter int SONG_BYTES = 256,  // bytes of song store per channel, 4..256
  parameter int CHANNELS   = 2     // channels served, 1..2
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // load_position[7:0], load_byte[15:8]
  input  logic [2:0]  s_tuser,   // func[1:0], channel[2]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // freq_low[7:0], freq_high[15:8], volume[20:16], zeros
  output logic [1:0]  m_tuser,   // out_channel[0], freq_valid[1]
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import nseq_pkg::*;

  localparam int DEPTH = CHANNELS * SONG_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = (SONG_BYTES > 1) ? $clog2(SONG_BYTES) : 1;

  typedef logic [MW-1:0] mod_tab_t [256];

  // byte position modulo the per-channel store size
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = MW'(i % SONG_BYTES);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TCNT = 4'd1;  // tick count + 1
  localparam logic [3:0] S_TDIF = 4'd2;  // duration - count, pick action
  localparam logic [3:0] S_RD0  = 4'd3;  // read frequency low
  localparam logic [3:0] S_RD1  = 4'd4;  // read frequency high
  localparam logic [3:0] S_RD2  = 4'd5;  // read duration
  localparam logic [3:0] S_RD3  = 4'd6;  // take duration, settle position
  localparam logic [3:0] S_MOD  = 4'd7;  // position remainder, one bit a cycle
  localparam logic [3:0] S_EMIT = 4'd8;  // hand result to output register

  logic [3:0] state;

  // input fields
  logic [1:0] in_func;
  logic       in_ch;
  logic [7:0] in_pos;
  logic [7:0] in_byte;
  logic       in_xfer;
  logic       in_ch_ok;

  assign in_func  = s_tuser[1:0];
  assign in_ch    = s_tuser[2];
  assign in_pos   = s_tdata[7:0];
  assign in_byte  = s_tdata[15:8];
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_ch_ok = (CHANNELS > 1) || (in_ch == 1'b0);

  // configuration
  logic [7:0] len_a;
  logic [7:0] len_b;

  // per-channel state
  logic [7:0] read_position [CH_SLOTS];
  logic [7:0] note_duration [CH_SLOTS];
  logic [7:0] tick_count    [CH_SLOTS];

  // working registers
  logic       ch;
  logic       is_tick;
  logic [7:0] wp;       // store position being read, then dividend
  logic [7:0] rem;      // partial remainder
  logic [2:0] bit_cnt;
  logic [7:0] flo;
  logic [7:0] fhi;
  logic [4:0] vol;
  logic       fv;

  // output register
  logic       o_ch;
  logic       o_fv;
  logic [7:0] o_flo;
  logic [7:0] o_fhi;
  logic [4:0] o_vol;

  logic [7:0] len_cur;
  assign len_cur = ch ? len_b : len_a;

  // shared add/subtract unit
  logic [8:0] alu_a;
  logic [8:0] alu_b;
  logic       alu_sub;
  logic [9:0] alu_res;
  logic [8:0] rem_sh;
  logic [7:0] rem_next;

  assign rem_sh = {rem, wp[7]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_TCNT: begin
        alu_a = {1'b0, tick_count[ch]};
        alu_b = 9'd1;
      end
      S_TDIF: begin
        alu_a   = {1'b0, note_duration[ch]};
        alu_b   = {1'b0, tick_count[ch]};
        alu_sub = 1'b1;
      end
      S_RD0, S_RD1: begin
        alu_a = {1'b0, wp};
        alu_b = 9'd1;
      end
      S_RD2: begin
        alu_a = {1'b0, wp};
        alu_b = 9'd2;
      end
      S_MOD: begin
        alu_a   = rem_sh;
        alu_b   = {1'b0, len_cur};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                            : ({1'b0, alu_a} + {1'b0, alu_b});
  // borrow clear means the shifted remainder reached the length
  assign rem_next = alu_res[9] ? rem_sh[7:0] : alu_res[7:0];

  // song store: one write, one registered read
  logic [7:0]    song_store [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          mem_we;

  assign mem_we = in_xfer && in_ch_ok && (in_func == FUNC_LOAD);
  assign waddr  = (in_ch ? AW'(SONG_BYTES) : AW'(0)) + AW'(MOD_TAB[in_pos]);
  assign raddr  = (ch ? AW'(SONG_BYTES) : AW'(0)) + AW'(MOD_TAB[wp]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      song_store[waddr] <= in_byte;
    end
    rdata <= song_store[raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= LEN_RESET;
      len_b <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEN_A: len_a <= cfg_data;
        REG_LEN_B: len_b <= cfg_data;
        default:   len_a <= len_a;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < CH_SLOTS; i++) begin
        read_position[i] <= '0;
        note_duration[i] <= '0;
        tick_count[i]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && in_ch_ok) begin
            ch <= in_ch;
            if (in_func == FUNC_TICK) begin
              is_tick <= 1'b1;
              state   <= S_TCNT;
            end else if (in_func == FUNC_START) begin
              // start plays the first record and leaves the count at one
              is_tick          <= 1'b0;
              wp               <= '0;
              fv               <= 1'b1;
              vol              <= VOL_NOTE;
              tick_count[in_ch] <= 8'd1;
              state            <= S_RD0;
            end
          end
        end
        S_TCNT: begin
          tick_count[ch] <= alu_res[7:0];
          state          <= S_TDIF;
        end
        S_TDIF: begin
          // wrapped ticks left in the note decide the action
          unique case (alu_res[7:0])
            8'd0: begin
              wp    <= read_position[ch];
              fv    <= 1'b1;
              vol   <= VOL_NOTE;
              state <= S_RD0;
            end
            8'd1: begin
              fv <= 1'b0; flo <= '0; fhi <= '0; vol <= VOL_FADE_1;
              state <= S_EMIT;
            end
            8'd2: begin
              fv <= 1'b0; flo <= '0; fhi <= '0; vol <= VOL_FADE_2;
              state <= S_EMIT;
            end
            8'd3: begin
              fv <= 1'b0; flo <= '0; fhi <= '0; vol <= VOL_FADE_3;
              state <= S_EMIT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_RD0: begin
          wp    <= alu_res[7:0];
          state <= S_RD1;
        end
        S_RD1: begin
          flo   <= rdata;
          wp    <= alu_res[7:0];
          state <= S_RD2;
        end
        S_RD2: begin
          fhi   <= rdata;
          wp    <= alu_res[7:0];  // record position plus four
          state <= S_RD3;
        end
        S_RD3: begin
          note_duration[ch] <= rdata;
          if (!is_tick) begin
            read_position[ch] <= wp;
            state             <= S_EMIT;
          end else begin
            tick_count[ch] <= '0;
            if (len_cur == 8'd0) begin
              // zero length acts as 256: position kept as is
              read_position[ch] <= wp;
              state             <= S_EMIT;
            end else begin
              rem     <= '0;
              bit_cnt <= 3'd7;
              state   <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem     <= rem_next;
          wp      <= {wp[6:0], 1'b0};
          bit_cnt <= bit_cnt - 3'd1;
          if (bit_cnt == 3'd0) begin
            read_position[ch] <= rem_next;
            state             <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  logic out_load;
  assign out_load = (state == S_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_ch  <= ch;
      o_fv  <= fv;
      o_flo <= flo;
      o_fhi <= fhi;
      o_vol <= vol;
    end
  end

  assign m_tdata = {3'b000, o_vol, o_fhi, o_flo};
  assign m_tuser = {o_fv, o_ch};

  // a fade result carries no frequency and one of the fade volumes
  a_fade_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |->
      (m_tdata[15:0] == 16'd0) &&
      (o_vol == VOL_FADE_1 || o_vol == VOL_FADE_2 || o_vol == VOL_FADE_3))
    else $error("fade result with frequency or bad volume");

  // a new note is always at full volume
  a_note_volume: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (o_vol == VOL_NOTE))
    else $error("new note not at full volume");

  // the remainder loop leaves the position below the song length
  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && ($past(state) == S_MOD)) |->
      (read_position[ch] < len_cur))
    else $error("read position not wrapped");

  // a start leaves the channel's tick count at one
  a_start_count: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_ch_ok && (in_func == FUNC_START)) |=> (tick_count[ch] == 8'd1))
    else $error("start did not set tick count");

endmodule

// ----- bench/tb_note_sequencer_with_release_fade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_note_sequencer_with_release_fade
// self-checking bench for the two-channel note sequencer with release fade
// ----------------------------------------------------------------------------
// A short table of directed transfers comes first: a tick straight after
// reset, the unused function code, loads of two records per channel and a
// start on each channel, followed by the fade ticks and the note change.
// Both song stores are then filled completely, so that no record read ever
// touches a byte that was never loaded. Random phases follow, each with its
// own pair of song lengths and one of four patterns of sender and receiver idling.
// Every accepted input transfer is run through a local model of the
// sequencer, and each result transfer is compared with the oldest note
// update still waiting.
// ----------------------------------------------------------------------------
module tb_note_sequencer_with_release_fade;
  import nseq_pkg::*;

  // the fourth function code is not used by the block and must be ignored
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // cycles the block may still be busy on a transfer that gives no result
  localparam int QUIET_CYCLES = 24;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  // random transfers per phase, func code 3 not counted
  localparam int PHASE_ITEMS  = 180;
  localparam int PHASES       = 8;

  // one input transfer
  typedef struct packed {
    logic [1:0] func;
    logic       ch;
    logic [7:0] pos;
    logic [7:0] data;
  } seq_item_t;

  // one note update on the result stream
  typedef struct packed {
    logic       ch;
    logic       fvalid;
    logic [7:0] flo;
    logic [7:0] fhi;
    logic [4:0] vol;
  } note_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,     // from the local model
    ROW_NO_NOTE,     // no result at all
    ROW_TYPED_NOTE   // the note typed into the row
  } row_kind_e;

  typedef struct packed {
    seq_item_t stim;
    row_kind_e kind;
    note_t     want;
  } dir_row_t;

  // dut ports
  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_LEN_A;
  logic [7:0]  cfg_data  = '0;

  // local model state
  logic [7:0] song_mem [CH_SLOTS][256];
  logic [7:0] rd_pos   [CH_SLOTS];
  logic [7:0] note_len [CH_SLOTS];
  logic [7:0] tick_cnt [CH_SLOTS];
  logic [7:0] len_a;
  logic [7:0] len_b;

  // note updates predicted but not yet seen on the result stream
  note_t pending_notes [$];
  dir_row_t directed_rows [$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;

  note_sequencer_with_release_fade dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("note_sequencer_with_release_fade test failed");
    $finish;
  end

  function automatic seq_item_t mk_item(logic [1:0] func, logic ch,
                                        logic [7:0] pos, logic [7:0] data);
    seq_item_t it;
    it.func = func;
    it.ch   = ch;
    it.pos  = pos;
    it.data = data;
    return it;
  endfunction

  function automatic note_t mk_note(logic ch, logic fvalid, logic [7:0] flo,
                                    logic [7:0] fhi, logic [4:0] vol);
    note_t n;
    n.ch     = ch;
    n.fvalid = fvalid;
    n.flo    = flo;
    n.fhi    = fhi;
    n.vol    = vol;
    return n;
  endfunction

  function automatic void add_row(seq_item_t stim, row_kind_e kind, note_t want);
    dir_row_t r;
    r.stim = stim;
    r.kind = kind;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // local model of the sequencer
  // ---------------------------------------------------------------------------
  task automatic reset_sequencer();
    for (int c = 0; c < CH_SLOTS; c++) begin
      for (int p = 0; p < 256; p++) song_mem[c][p] = '0;
      rd_pos[c]   = '0;
      note_len[c] = '0;
      tick_cnt[c] = '0;
    end
    len_a = LEN_RESET;
    len_b = LEN_RESET;
  endtask

  // read the record at the read position and step on by one record
  task automatic play_record(input logic ch, output note_t n);
    logic [7:0] p;
    p = rd_pos[ch];
    n = mk_note(ch, 1'b1, song_mem[ch][p], song_mem[ch][8'(p + 8'd1)], VOL_NOTE);
    note_len[ch] = song_mem[ch][8'(p + 8'd2)];
    rd_pos[ch]   = 8'(p + 8'd4);
  endtask

  task automatic step_sequencer(input seq_item_t it, output bit emits, output note_t n);
    logic [7:0] rem;
    int         wrap_len;
    emits = 1'b0;
    n     = '0;
    case (it.func)
      FUNC_LOAD: begin
        song_mem[it.ch][it.pos] = it.data;
      end
      FUNC_START: begin
        // start always plays record zero and leaves the position at 4
        rd_pos[it.ch] = '0;
        play_record(it.ch, n);
        tick_cnt[it.ch] = 8'd1;
        emits = 1'b1;
      end
      FUNC_TICK: begin
        tick_cnt[it.ch] = 8'(tick_cnt[it.ch] + 8'd1);
        rem = 8'(note_len[it.ch] - tick_cnt[it.ch]);
        case (rem)
          8'd0: begin
            play_record(it.ch, n);
            wrap_len = it.ch ? int'(len_b) : int'(len_a);
            // a zero length stands for the full 256 bytes
            if (wrap_len == 0) wrap_len = 256;
            rd_pos[it.ch]   = 8'(int'(rd_pos[it.ch]) % wrap_len);
            tick_cnt[it.ch] = '0;
            emits = 1'b1;
          end
          8'd3: begin
            n = mk_note(it.ch, 1'b0, 8'd0, 8'd0, VOL_FADE_3);
            emits = 1'b1;
          end
          8'd2: begin
            n = mk_note(it.ch, 1'b0, 8'd0, 8'd0, VOL_FADE_2);
            emits = 1'b1;
          end
          8'd1: begin
            n = mk_note(it.ch, 1'b0, 8'd0, 8'd0, VOL_FADE_1);
            emits = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;  // spare code: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // sender side: all driving happens at the falling edge
  // ---------------------------------------------------------------------------
  // called at a falling edge, returns at a falling edge with s_tvalid still up
  task automatic send_item(input seq_item_t it, input row_kind_e kind, input note_t want);
    bit    emits;
    note_t n;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.data, it.pos};
    s_tuser  <= {it.ch, it.func};
    do @(posedge clk); while (!s_tready);
    // transfer taken at this edge
    step_sequencer(it, emits, n);
    case (kind)
      ROW_PREDICT:    if (emits) pending_notes.push_back(n);
      ROW_TYPED_NOTE: pending_notes.push_back(want);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // stop offering, wait for every outstanding note, then stay quiet a while
  task automatic drain_results(input int quiet);
    s_tvalid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (quiet) @(negedge clk);
  endtask

  // both writes only while the block is idle
  task automatic set_song_lengths(input logic [7:0] a, input logic [7:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEN_A;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= REG_LEN_B;
    cfg_data  <= b;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_a = a;
    len_b = b;
  endtask

  // note lengths mostly short so that notes and fades come often
  function automatic logic [7:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 4) return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    if (r < 8) return 8'($urandom_range(255));
    return 8'($urandom_range(12, 1));
  endfunction

  function automatic seq_item_t random_item();
    int         r;
    logic [7:0] p;
    logic       c;
    r = $urandom_range(99);
    c = 1'($urandom_range(1));
    p = 8'($urandom_range(255));
    if (r < 70) return mk_item(FUNC_TICK, c, p, 8'($urandom_range(255)));
    if (r < 82)
      return mk_item(FUNC_LOAD, c, p,
                     (p[1:0] == 2'd2) ? pick_duration() : 8'($urandom_range(255)));
    if (r < 94) return mk_item(FUNC_START, c, p, 8'($urandom_range(255)));
    return mk_item(FUNC_SPARE, c, p, 8'($urandom_range(255)));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         sent;
    seq_item_t  it;
    logic [7:0] len_a_plan [PHASES];
    logic [7:0] len_b_plan [PHASES];
    int         idle_send  [4];
    int         idle_recv  [4];

    // song lengths per phase: extremes, zero, lengths off the record grid
    len_a_plan = '{8'd4, 8'd252, 8'd0, 8'd12, 8'd7, 8'd128, 8'd255, 8'd4};
    len_b_plan = '{8'd252, 8'd4, 8'd32, 8'd0, 8'd100, 8'd255, 8'd9, 8'd4};
    len_a_plan[PHASES-1] = 8'($urandom_range(63, 1) * 4);
    len_b_plan[PHASES-1] = 8'($urandom_range(63, 1) * 4);
    // no idling, sender idle, receiver stalling, both
    idle_send = '{0, 84, 0, 24};
    idle_recv = '{0, 0, 84, 24};

    reset_sequencer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, song lengths still at their reset value of 4
    // ch0 record 0: ff 00 dur 5, record 1: 00 ff dur 1
    // ch1 record 0: 5a a5 dur 4, record 1: ff ff dur 3
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_SPARE, 1'b1, 8'hff, 8'hff), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd0, 8'hff), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd1, 8'h00), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd2, 8'd5), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd4, 8'h00), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd5, 8'hff), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b0, 8'd6, 8'd1), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd0, 8'h5a), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd1, 8'ha5), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd2, 8'd4), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd4, 8'hff), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd5, 8'hff), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_LOAD, 1'b1, 8'd6, 8'd3), ROW_NO_NOTE, '0);
    add_row(mk_item(FUNC_START, 1'b0, 8'h00, 8'h00), ROW_TYPED_NOTE,
            mk_note(1'b0, 1'b1, 8'hff, 8'h00, VOL_NOTE));
    // three fade steps, then record 1
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_PREDICT, '0);
    // one-tick note, position wrapped back to record 0
    add_row(mk_item(FUNC_TICK, 1'b0, 8'h00, 8'h00), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_START, 1'b1, 8'hff, 8'hff), ROW_TYPED_NOTE,
            mk_note(1'b1, 1'b1, 8'h5a, 8'ha5, VOL_NOTE));
    add_row(mk_item(FUNC_TICK, 1'b1, 8'hff, 8'hff), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_TICK, 1'b1, 8'hff, 8'hff), ROW_PREDICT, '0);
    add_row(mk_item(FUNC_TICK, 1'b1, 8'hff, 8'hff), ROW_PREDICT, '0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].kind, directed_rows[i].want);

    // fill both stores completely, durations mostly short
    drain_results(QUIET_CYCLES);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    for (int c = 0; c < CH_SLOTS; c++) begin
      for (int p = 0; p < 256; p++) begin
        it = mk_item(FUNC_LOAD, 1'(c), 8'(p),
                     (p % 4 == 2) ? pick_duration() : 8'($urandom_range(255)));
        send_item(it, ROW_PREDICT, '0);
      end
    end

    // random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results(QUIET_CYCLES);
      set_song_lengths(len_a_plan[ph], len_b_plan[ph]);
      send_idle_pct  = idle_send[ph % 4];
      recv_stall_pct = idle_recv[ph % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 0 && sent == 60) hold_requests++;
        // sender pause until every note is out
        if (ph == 2 && sent == 120) drain_results(0);
        it = random_item();
        if (it.func != FUNC_SPARE) sent++;
        send_item(it, ROW_PREDICT, '0);
      end
    end

    drain_results(QUIET_CYCLES + 16);
    if (mismatches == 0 && pending_notes.size() == 0) begin
      $display("note_sequencer_with_release_fade test passed");
    end else begin
      $display("note_sequencer_with_release_fade test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking at the rising edge
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input note_t want, input note_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected ch %0d fv %0d lo %02h hi %02h vol %0d",
               $time, what, want.ch, want.fvalid, want.flo, want.fhi, want.vol);
      $display("%0t %s: got ch %0d fv %0d lo %02h hi %02h vol %0d",
               $time, what, got.ch, got.fvalid, got.flo, got.fhi, got.vol);
    end
  endtask

  always @(posedge clk) begin
    note_t got;
    note_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = mk_note(m_tuser[0], m_tuser[1], m_tdata[7:0], m_tdata[15:8], m_tdata[20:16]);
      if (pending_notes.size() == 0) begin
        flag_mismatch("result transfer with nothing expected", '0, got);
      end else begin
        want = pending_notes.pop_front();
        if (got.ch !== want.ch || got.fvalid !== want.fvalid || got.flo !== want.flo ||
            got.fhi !== want.fhi || got.vol !== want.vol)
          flag_mismatch("note update mismatch", want, got);
      end
    end
  end

endmodule
